/* design/tppd_pkg.sv */
// Package for the touch pad press detector.
// Holds the request types, configuration register codes, widths and reset values.
// No dependencies.
package tppd_pkg;

	localparam int SAMPLE_W   = 22;
	localparam int FRAC_W     = 16;
	localparam int BASE_W     = SAMPLE_W + FRAC_W;
	localparam int RISE_W     = 7;
	localparam int WEIGHT_W   = 16;
	localparam int TICKS_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [RISE_W-1:0]   RISE_RESET    = 7'd20;
	localparam logic                ACTIVE_RESET  = 1'b1;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 16'd328;
	localparam logic [TICKS_W-1:0]  TICKS_RESET   = 16'd75;

	// scale of a raw reading against the Q16 baseline times 100
	localparam logic [22:0] SAMPLE_SCALE = 23'd6553600;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RISE_PERCENT   = 2'd0,
		REG_ACTIVE_HIGH    = 2'd1,
		REG_DRIFT_WEIGHT   = 2'd2,
		REG_BLACKOUT_TICKS = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                capture_done;
	} tppd_in_t;

	typedef struct packed {
		logic                touched;
		logic                pressed;
		logic                fired;
		logic                ignored;
		logic                calibrating;
		logic [SAMPLE_W-1:0] baseline_level;
	} tppd_out_t;

	typedef struct packed {
		logic [RISE_W-1:0]   rise_percent;
		logic                active_high;
		logic [WEIGHT_W-1:0] drift_weight;
	} track_cfg_t;

	typedef struct packed {
		logic              calibrating;
		logic              last;
		logic [BASE_W-1:0] init_base;
	} calib_stat_t;

endpackage

/* design/tppd_calib.sv */
// Initial baseline average for the touch pad press detector.
// Keeps the running sum as quotient and remainder by CALIB_SAMPLES; uses tppd_pkg.
module tppd_calib #(
	parameter int CALIB_SAMPLES = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [tppd_pkg::SAMPLE_W-1:0] v,
	output tppd_pkg::calib_stat_t         stat
);
	import tppd_pkg::*;

	localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);
	localparam int REM_W = 5;
	localparam int X_W   = SAMPLE_W + 1;
	localparam int K     = X_W + REM_W;
	localparam int TN_W  = X_W + REM_W;
	// reciprocal of CALIB_SAMPLES, exact for every numerator below 2^X_W
	localparam logic [K:0] RECIP =
		(K+1)'(((64'd1 << K) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));

	logic [CNT_W-1:0]    count_q;
	logic [SAMPLE_W-1:0] quot_q;
	logic [REM_W-1:0]    rem_q;

	logic [X_W-1:0]        x;
	logic [X_W+K:0]        qprod;
	logic [X_W-1:0]        t;
	logic [TN_W-1:0]       r_full;
	logic [REM_W-1:0]      rem_d;
	logic [X_W-1:0]        quot_sum;
	logic [FRAC_W-1:0]     frac_tab [2**REM_W];

	// fractional part of r * 65536 / CALIB_SAMPLES for each remainder
	for (genvar i = 0; i < 2**REM_W; i++) begin : g_frac
		assign frac_tab[i] = FRAC_W'((64'(i) << FRAC_W) / 64'(CALIB_SAMPLES));
	end

	always_comb begin
		x        = X_W'(rem_q) + X_W'(v);
		qprod    = (X_W+K+1)'(x) * (X_W+K+1)'(RECIP);
		t        = qprod[K +: X_W];
		r_full   = TN_W'(x) - TN_W'(t) * TN_W'(CALIB_SAMPLES);
		rem_d    = r_full[REM_W-1:0];
		quot_sum = X_W'(quot_q) + t;
	end

	always_comb begin
		stat.calibrating = count_q < CNT_W'(CALIB_SAMPLES);
		stat.last        = count_q == CNT_W'(CALIB_SAMPLES - 1);
		stat.init_base   = {quot_sum[SAMPLE_W-1:0], frac_tab[rem_d]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			quot_q  <= '0;
			rem_q   <= '0;
		end else if (step && stat.calibrating) begin
			count_q <= count_q + CNT_W'(1);
			quot_q  <= quot_sum[SAMPLE_W-1:0];
			rem_q   <= rem_d;
		end
	end

endmodule

/* design/tppd_track.sv */
// Baseline register, touch threshold compare and drift tracking.
// Uses tppd_pkg and the status of tppd_calib.
module tppd_track (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [tppd_pkg::SAMPLE_W-1:0] v,
	input  tppd_pkg::calib_stat_t         cal,
	input  tppd_pkg::track_cfg_t          cfg,
	output logic                          touched,
	output logic [tppd_pkg::SAMPLE_W-1:0] level
);
	import tppd_pkg::*;

	localparam int CMP_W  = BASE_W + 8;
	localparam int DIFF_W = BASE_W + 1;
	localparam int PROD_W = DIFF_W + WEIGHT_W + 1;

	logic [BASE_W-1:0] baseline_q;
	logic [BASE_W-1:0] baseline_d;

	logic [7:0]                factor;
	logic [CMP_W-1:0]          lhs;
	logic [CMP_W-1:0]          rhs;
	logic                      past;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  rounded;
	logic signed [BASE_W+1:0]  drifted;

	always_comb begin
		// falling polarity with a percent of 100 or more leaves a zero limit
		if (cfg.active_high) begin
			factor = 8'd100 + 8'(cfg.rise_percent);
		end else if (cfg.rise_percent >= 7'd100) begin
			factor = '0;
		end else begin
			factor = 8'(7'd100 - cfg.rise_percent);
		end
		lhs  = CMP_W'(v) * CMP_W'(SAMPLE_SCALE);
		rhs  = CMP_W'(baseline_q) * CMP_W'(factor);
		past = cfg.active_high ? (lhs > rhs) : (lhs < rhs);
		touched = !cal.calibrating && past;
	end

	// baseline + round(w * ((v << 16) - baseline) / 65536)
	always_comb begin
		diff    = $signed({1'b0, v, {FRAC_W{1'b0}}}) - $signed({1'b0, baseline_q});
		prod    = PROD_W'(diff) * $signed({1'b0, cfg.drift_weight});
		rounded = prod + PROD_W'(32768);
		drifted = $signed({2'b00, baseline_q}) + rounded[PROD_W-1 -: (BASE_W+2)];
	end

	always_comb begin
		priority if (cal.calibrating) begin
			baseline_d = cal.last ? cal.init_base : baseline_q;
		end else if (!past) begin
			baseline_d = drifted[BASE_W-1:0];
		end else begin
			baseline_d = baseline_q;
		end
		level = baseline_d[BASE_W-1 -: SAMPLE_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q <= '0;
		end else if (step) begin
			baseline_q <= baseline_d;
		end
	end

endmodule

/* design/touch_pad_press_detector.sv */
// Top level of the touch pad press detector: input register, press and blackout
// logic, result register and configuration registers. Uses tppd_pkg, tppd_calib, tppd_track.
//
//  port group  direction  handshake             payload
//  in          request in in_valid / in_stall   in_data  (sample, capture_done)
//  out         result out  out_valid / out_stall out_data (touched .. baseline_level)
//  cfg         write in    cfg_en               cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low. The input register feeds the threshold
// and drift multipliers, which load the result register when the request advances out of the
// input register. The baseline loop closes at that same edge.
// Reset clears the calibration count, baseline, blackout and all valid flags.
// A held out_stall freezes the result register; one more request waits in the input
// register, then in_stall rises.
module touch_pad_press_detector #(
	parameter int CALIB_SAMPLES = 25,
	parameter int SAMPLE_BITS   = 22
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  tppd_pkg::tppd_in_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output tppd_pkg::tppd_out_t             out_data,
	input  logic                            cfg_en,
	input  logic [tppd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tppd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tppd_pkg::*;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = (SAMPLE_BITS >= SAMPLE_W) ? '1 :
		SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

	logic [RISE_W-1:0]   rise_q;
	logic                active_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [TICKS_W-1:0]  ticks_q;

	logic                valid_s1;
	logic [SAMPLE_W-1:0] v_s1;
	logic                cap_s1;
	logic                valid_s2;
	tppd_out_t           out_s2;

	logic [TICKS_W-1:0]  blackout_q;
	logic                was_touched_q;

	logic        adv;
	logic        take;
	calib_stat_t cal;
	track_cfg_t  tcfg;
	logic        touched;
	logic [SAMPLE_W-1:0] level;
	tppd_out_t   res;

	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign take     = in_valid && !in_stall;

	assign tcfg.rise_percent = rise_q;
	assign tcfg.active_high  = active_q;
	assign tcfg.drift_weight = weight_q;

	tppd_calib #(
		.CALIB_SAMPLES(CALIB_SAMPLES)
	) u_calib (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.v      (v_s1),
		.stat   (cal)
	);

	tppd_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.v       (v_s1),
		.cal     (cal),
		.cfg     (tcfg),
		.touched (touched),
		.level   (level)
	);

	always_comb begin
		res.touched        = touched;
		res.pressed        = touched && !was_touched_q;
		res.fired          = res.pressed && (blackout_q == '0);
		res.ignored        = res.pressed && (blackout_q != '0);
		res.calibrating    = cal.calibrating;
		res.baseline_level = level;
	end

	assign out_valid = valid_s2;
	assign out_data  = out_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q   <= RISE_RESET;
			active_q <= ACTIVE_RESET;
			weight_q <= WEIGHT_RESET;
			ticks_q  <= TICKS_RESET;
		end else if (cfg_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RISE_PERCENT:   rise_q   <= cfg_data[RISE_W-1:0];
				REG_ACTIVE_HIGH:    active_q <= cfg_data[0];
				REG_DRIFT_WEIGHT:   weight_q <= cfg_data[WEIGHT_W-1:0];
				REG_BLACKOUT_TICKS: ticks_q  <= cfg_data[TICKS_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			v_s1   <= in_data.sample & SAMPLE_MASK;
			cap_s1 <= in_data.capture_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s2 <= res;
		end
	end

	// press decision above saw the count as it stood; reload or count down now
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blackout_q    <= '0;
			was_touched_q <= 1'b0;
		end else if (adv) begin
			was_touched_q <= touched;
			if (cap_s1) begin
				blackout_q <= ticks_q;
			end else if (blackout_q != '0) begin
				blackout_q <= blackout_q - TICKS_W'(1);
			end
		end
	end

	a_cap_loads_blackout: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cap_s1 |=> blackout_q == $past(ticks_q))
		else $error("blackout not loaded on capture_done");

	a_edge_memory: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> was_touched_q == out_s2.touched)
		else $error("edge memory out of step with result");

	a_no_touch_while_cal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_s2.calibrating |-> !out_s2.touched && !out_s2.pressed)
		else $error("touch reported during calibration");

	a_fire_outside_blackout: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.fired |-> blackout_q == '0 && !res.ignored)
		else $error("press fired inside blackout");

endmodule

/* tb/sv/tb_touch_pad_press_detector.sv */
// Testbench for touch_pad_press_detector: runs calibration and threshold cases, then random
// press sequences across several register settings, and checks each result against a predictor.
// Depends on tppd_pkg and the touch_pad_press_detector RTL.
module tb_touch_pad_press_detector;
	import tppd_pkg::*;

	localparam int CALIB_LEN = 25;
	localparam longint SAMPLE_MAX = (64'd1 << SAMPLE_W) - 1;
	localparam int LONG_HOLD = 300;
	localparam int QUIET_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	tppd_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	tppd_out_t out_data;
	logic cfg_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	touch_pad_press_detector DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_en(cfg_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// register copies as the block should hold them
	logic [RISE_W-1:0] cfg_rise = RISE_RESET;
	logic cfg_active = ACTIVE_RESET;
	logic [WEIGHT_W-1:0] cfg_weight = WEIGHT_RESET;
	logic [TICKS_W-1:0] cfg_ticks = TICKS_RESET;

	// tracker state, Q16 baseline kept wide for the products
	logic [63:0] base_q16 = '0;
	logic [26:0] calib_acc = '0;
	int calib_n = 0;
	logic prev_touch = 1'b0;
	logic [TICKS_W-1:0] blackout_cnt = '0;

	tppd_in_t readings_pending[$];
	tppd_out_t reports_due[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req = 0;
	int send_gap = 0;
	int recv_wait = 0;
	int hold_seen = 0;
	int quiet_cycles = 0;

	function automatic int draw_wait(int pct);
		return ($urandom_range(0, 99) < pct) ? $urandom_range(1, 6) : 0;
	endfunction

	function automatic tppd_out_t predict_press_report(tppd_in_t req);
		logic [63:0] v, lhs, scale, w;
		tppd_out_t r;
		v = {42'b0, req.sample};
		r = '0;
		if (calib_n < CALIB_LEN) begin
			r.calibrating = 1'b1;
			calib_acc = calib_acc + req.sample;
			calib_n++;
			if (calib_n == CALIB_LEN)
				base_q16 = ({37'b0, calib_acc} << FRAC_W) / 64'(CALIB_LEN);
		end else begin
			lhs = v * 64'd6553600;
			if (cfg_active)
				r.touched = lhs > base_q16 * (64'd100 + cfg_rise);
			else begin
				// falling polarity past 100 percent has no low limit left
				scale = (cfg_rise >= 7'd100) ? 64'd0 : 64'd100 - cfg_rise;
				r.touched = lhs < base_q16 * scale;
			end
			r.pressed = r.touched && !prev_touch;
			r.fired = r.pressed && blackout_cnt == 0;
			r.ignored = r.pressed && blackout_cnt != 0;
			if (!r.touched) begin
				w = cfg_weight;
				base_q16 = (base_q16 * (64'd65536 - w) + (v << FRAC_W) * w + 64'd32768) >> FRAC_W;
			end
			prev_touch = r.touched;
		end
		// blackout decision above uses the count from the start of the tick
		if (req.capture_done)
			blackout_cnt = cfg_ticks;
		else if (blackout_cnt != 0)
			blackout_cnt = blackout_cnt - 1'b1;
		r.baseline_level = base_q16[BASE_W-1:FRAC_W];
		return r;
	endfunction

	task automatic compare_field(string name, logic [SAMPLE_W-1:0] want, logic [SAMPLE_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_report(tppd_out_t want, tppd_out_t got);
		compare_field("touched", want.touched, got.touched);
		compare_field("pressed", want.pressed, got.pressed);
		compare_field("fired", want.fired, got.fired);
		compare_field("ignored", want.ignored, got.ignored);
		compare_field("calibrating", want.calibrating, got.calibrating);
		compare_field("baseline_level", want.baseline_level, got.baseline_level);
	endtask

	// sender: predict on acceptance, then hold, idle or present the next request
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall)
				reports_due.push_back(predict_press_report(in_data));
			if (in_valid && in_stall) begin
				in_valid <= 1'b1;
			end else if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (readings_pending.size() != 0) begin
				in_data <= readings_pending.pop_front();
				in_valid <= 1'b1;
				send_gap <= draw_wait(send_idle_pct);
			end else
				in_valid <= 1'b0;
		end
	end

	// receiver: check each result, then stall per result or for a long hold-off
	always @(posedge clk) begin : receiver
		int n;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait <= 0;
			hold_seen <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (reports_due.size() == 0) begin
					$display("%0t: result with none expected, actual %p", $time, out_data);
					errors++;
				end else
					check_report(reports_due.pop_front(), out_data);
			end
			if (hold_seen != hold_req) begin
				hold_seen <= hold_req;
				recv_wait <= LONG_HOLD;
				out_stall <= 1'b1;
			end else if (recv_wait != 0) begin
				recv_wait <= recv_wait - 1;
				out_stall <= 1'b1;
			end else if (out_valid && !out_stall) begin
				n = draw_wait(recv_idle_pct);
				out_stall <= (n != 0);
				recv_wait <= (n != 0) ? n - 1 : 0;
			end else
				out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
				$display("tb_touch_pad_press_detector NOT OK");
				$finish;
			end
		end
	end

	task automatic push_reading(longint s, bit cap);
		tppd_in_t r;
		if (s < 0)
			s = 0;
		if (s > SAMPLE_MAX)
			s = SAMPLE_MAX;
		r.sample = s[SAMPLE_W-1:0];
		r.capture_done = cap;
		readings_pending.push_back(r);
	endtask

	task automatic wait_idle;
		@(negedge clk);
		while (readings_pending.size() != 0 || in_valid || reports_due.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_RISE_PERCENT: cfg_rise = value[RISE_W-1:0];
			REG_ACTIVE_HIGH: cfg_active = value[0];
			REG_DRIFT_WEIGHT: cfg_weight = value[WEIGHT_W-1:0];
			REG_BLACKOUT_TICKS: cfg_ticks = value[TICKS_W-1:0];
			default: ;
		endcase
	endtask

	// quiet stretches near the baseline, then a touch well past the threshold, mixed with random readings
	task automatic queue_press_sequences(int count);
		longint b, rise, band, hi, lo;
		int k, quiet_n, touch_n;
		b = base_q16[BASE_W-1:FRAC_W];
		rise = cfg_rise;
		band = b * rise / 300 + 1;
		hi = b * (100 + rise) / 100 + b / 8 + 1;
		lo = (rise >= 100) ? 0 : b * (100 - rise) / 100 - b / 8 - 1;
		k = 0;
		while (k < count) begin
			if ($urandom_range(0, 99) < 15) begin
				push_reading($urandom_range(0, SAMPLE_MAX), $urandom_range(0, 99) < 8);
				k++;
			end else begin
				quiet_n = $urandom_range(1, 5);
				touch_n = $urandom_range(1, 4);
				repeat (quiet_n)
					push_reading(b - band + $urandom_range(0, 2 * band),
						$urandom_range(0, 99) < 8);
				repeat (touch_n) begin
					if (cfg_active)
						push_reading(hi + $urandom_range(0, b / 4), $urandom_range(0, 99) < 8);
					else
						push_reading(lo - $urandom_range(0, lo / 4 + 1),
							$urandom_range(0, 99) < 8);
				end
				k += quiet_n + touch_n;
			end
		end
	endtask

	task automatic run_phase(logic [15:0] rise, logic [15:0] active, logic [15:0] weight,
			logic [15:0] ticks, int send_pct, int recv_pct, bit long_hold, int count);
		wait_idle();
		write_reg(REG_RISE_PERCENT, rise);
		write_reg(REG_ACTIVE_HIGH, active);
		write_reg(REG_DRIFT_WEIGHT, weight);
		write_reg(REG_BLACKOUT_TICKS, ticks);
		@(posedge clk);
		cfg_en <= 1'b0;
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		if (long_hold)
			hold_req++;
		queue_press_sequences(count);
	endtask

	initial begin : stimulus
		longint b, at_limit;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// calibration: field extremes and a blackout started while averaging
		push_reading(0, 1'b0);
		push_reading(SAMPLE_MAX, 1'b0);
		push_reading(22'h2AAAAA, 1'b1);
		push_reading(22'h155555, 1'b0);
		for (int i = 4; i < CALIB_LEN; i++)
			push_reading(1000000 + $urandom_range(0, 65535), i == 20);
		wait_idle();

		// both sides of the threshold, then presses inside the blackout
		b = base_q16[BASE_W-1:FRAC_W];
		at_limit = (base_q16 * 120) / 6553600;
		push_reading(at_limit + 1, 1'b0);
		push_reading(at_limit, 1'b0);
		push_reading(SAMPLE_MAX, 1'b1);
		push_reading(SAMPLE_MAX, 1'b0);
		push_reading(0, 1'b0);
		push_reading(b, 1'b0);
		push_reading(22'h2AAAAA, 1'b0);
		push_reading(22'h155555, 1'b1);

		run_phase(16'd0, 16'd1, 16'd0, 16'd0, 0, 0, 1'b0, 60);
		// percent written with high bits set lands on 100
		run_phase(16'hFFE4, 16'd1, 16'hFFFF, 16'd5, 40, 40, 1'b0, 60);
		run_phase(16'd127, 16'd0, 16'd4000, 16'd12, 0, 10, 1'b1, 60);
		run_phase(16'd30, 16'd0, 16'd1000, 16'd8, 50, 50, 1'b0, 60);
		run_phase(16'd10, 16'd1, 16'd328, 16'hFFFF, 20, 60, 1'b0, 50);
		run_phase(16'd50, 16'hFFFE, 16'hFFFF, 16'd3, 60, 20, 1'b0, 50);
		run_phase(16'd20, 16'd1, 16'd328, 16'd2, 30, 30, 1'b1, 60);

		wait_idle();
		repeat (4) @(posedge clk);
		if (reports_due.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, reports_due.size());
			errors++;
		end
		if (errors == 0)
			$display("tb_touch_pad_press_detector OK");
		else
			$display("tb_touch_pad_press_detector NOT OK");
		$finish;
	end
endmodule

/* touch_pad_press_detector.f */
design/tppd_pkg.sv
design/tppd_calib.sv
design/tppd_track.sv
design/touch_pad_press_detector.sv
tb/sv/tb_touch_pad_press_detector.sv
